FILE: sv/cascadable_four_channel_timer_unit_assert.svh
// assertion macros for the cascadable timer unit
// expects clk_i and rst_ni in the scope that uses them
`ifndef CASCADABLE_FOUR_CHANNEL_TIMER_UNIT_ASSERT_SVH
`define CASCADABLE_FOUR_CHANNEL_TIMER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CFTU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CFTU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cftu_pkg.sv
// shared types, constants and helpers of the cascadable timer unit
// no dependencies
package cftu_pkg;

  // default number of timers
  localparam int NumTimersDef = 4;

  // payload widths
  localparam int KindW    = 2;
  localparam int TSelW    = 2;
  localparam int DataW    = 16;
  localparam int CtlW     = 8;
  localparam int PhaseW   = 11;
  localparam int IrqW     = 4;
  localparam int InUserW  = 5;
  localparam int InDataW  = 32;
  localparam int OutDataW = 24;

  // item kinds, code 3 is unused and does nothing
  typedef enum logic [KindW-1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  // register select
  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_CTRL  = 1'b1;

  // control byte layout
  localparam int CtlEnableBit  = 7;
  localparam int CtlIrqBit     = 6;
  localparam int CtlCascadeBit = 2;
  localparam logic [CtlW-1:0] CtlWritable = 8'hC7;

  // last phase value of one prescale period (2^shift - 1)
  function automatic logic [PhaseW-1:0] last_phase(input logic [1:0] presc,
                                                  input logic       casc);
    logic [PhaseW-1:0] last;
    last = PhaseW'(1);
    if (!casc) begin
      unique case (presc)
        2'd0:    last = PhaseW'(1);
        2'd1:    last = PhaseW'(127);
        2'd2:    last = PhaseW'(511);
        default: last = PhaseW'(2047);
      endcase
    end
    return last;
  endfunction

endpackage

FILE: sv/cascadable_four_channel_timer_unit.sv
// top level of the cascadable timer unit: bank of up-counters with prescalers
// depends on cftu_pkg and cascadable_four_channel_timer_unit_assert.svh
//
// usage
// - slave stream takes one item per cycle while the receiver keeps up: a base
//   clock tick, a register read or a register write; the kind, timer and register
//   select ride in tuser, the byte mask and write data in tdata
// - master stream returns exactly one result per item: read data (zero unless
//   a read) and a per-timer overflow irq pulse (nonzero only on ticks)
// - an accepted item passes through the input register, then the result register,
//   before its result appears on the master side
// - throughput: one item per clock while the receiver keeps up; the whole tick,
//   including the overflow ripple through every cascaded timer, resolves
//   combinationally between the input register and the result register
// - when the receiver stalls, the result register holds its item and the
//   input register holds the next one; s_axis_tready drops only when both
//   are full, so no item is lost or repeated
// - reset clears all counters, reload values, control bytes and prescale
//   phases, so every timer starts disabled; both stream sides come up empty
`include "cascadable_four_channel_timer_unit_assert.svh"

module cascadable_four_channel_timer_unit
  import cftu_pkg::*;
#(
  parameter int NUM_TIMERS = NumTimersDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // byte_mask[15:0], wdata[31:16]
  input  logic [InUserW-1:0]  s_axis_tuser,   // kind[1:0], timer_sel[3:2], reg_sel[4]
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // read_data[15:0], irq_pulse[19:16], zero
);

  // input register
  logic              in_valid_q;
  kind_e             kind_q;
  logic [TSelW-1:0]  timer_sel_q;
  logic              reg_sel_q;
  logic [DataW-1:0]  byte_mask_q;
  logic [DataW-1:0]  wdata_q;

  // result register
  logic              out_valid_q;
  logic [DataW-1:0]  read_data_q, read_data_d;
  logic [IrqW-1:0]   irq_q, irq_d;

  // timer state
  logic [DataW-1:0]  cnt_q    [NUM_TIMERS];
  logic [DataW-1:0]  cnt_d    [NUM_TIMERS];
  logic [DataW-1:0]  reload_q [NUM_TIMERS];
  logic [DataW-1:0]  reload_d [NUM_TIMERS];
  logic [CtlW-1:0]   ctl_q    [NUM_TIMERS];
  logic [CtlW-1:0]   ctl_d    [NUM_TIMERS];
  logic [PhaseW-1:0] phase_q  [NUM_TIMERS];
  logic [PhaseW-1:0] phase_d  [NUM_TIMERS];

  logic                       s_accept;
  logic                       advance;
  logic [NUM_TIMERS-1:0]      irq_hit;
  logic [NUM_TIMERS+IrqW-1:0] irq_wide;
  logic                       ctl_rsvd_any;

  // the stored item moves into the result register when that one is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      kind_q      <= kind_e'(s_axis_tuser[1:0]);
      timer_sel_q <= s_axis_tuser[3:2];
      reg_sel_q   <= s_axis_tuser[4];
      byte_mask_q <= s_axis_tdata[15:0];
      wdata_q     <= s_axis_tdata[31:16];
    end
  end

  // next state of all timers and the result of the stored item
  always_comb begin
    logic              carry;
    logic              casc;
    logic              casc_new;
    logic              inc;
    logic              wrap;
    logic              hit;
    logic              rise;
    logic              restart;
    logic [CtlW-1:0]   wmask;
    logic [CtlW-1:0]   ctl_new;

    carry       = 1'b0;
    casc        = 1'b0;
    casc_new    = 1'b0;
    inc         = 1'b0;
    wrap        = 1'b0;
    hit         = 1'b0;
    rise        = 1'b0;
    restart     = 1'b0;
    wmask       = '0;
    ctl_new     = '0;
    read_data_d = '0;
    irq_hit     = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      cnt_d[t]    = cnt_q[t];
      reload_d[t] = reload_q[t];
      ctl_d[t]    = ctl_q[t];
      phase_d[t]  = phase_q[t];
    end

    if (advance) begin
      unique case (kind_q)
        KIND_TICK: begin
          // timers in order, a wrap ripples into the next cascaded timer
          for (int t = 0; t < NUM_TIMERS; t++) begin
            casc = (t != 0) && ctl_q[t][CtlCascadeBit];
            inc  = 1'b0;
            if (ctl_q[t][CtlEnableBit]) begin
              if (casc) begin
                inc = carry;
              end else if (phase_q[t] >= last_phase(ctl_q[t][1:0], 1'b0)) begin
                phase_d[t] = '0;
                inc        = 1'b1;
              end else begin
                phase_d[t] = phase_q[t] + PhaseW'(1);
              end
            end
            wrap = inc && (cnt_q[t] == {DataW{1'b1}});
            if (inc) begin
              cnt_d[t] = wrap ? reload_q[t] : cnt_q[t] + DataW'(1);
            end
            irq_hit[t] = wrap && ctl_q[t][CtlIrqBit];
            carry      = wrap;
          end
        end
        KIND_READ: begin
          for (int t = 0; t < NUM_TIMERS; t++) begin
            hit = (t < (1 << TSelW)) && (timer_sel_q == TSelW'(t));
            if (hit) begin
              read_data_d = (reg_sel_q == REG_CTRL) ? {{(DataW-CtlW){1'b0}}, ctl_q[t]}
                                                    : cnt_q[t];
            end
          end
        end
        KIND_WRITE: begin
          for (int t = 0; t < NUM_TIMERS; t++) begin
            hit = (t < (1 << TSelW)) && (timer_sel_q == TSelW'(t));
            if (hit) begin
              if (reg_sel_q == REG_COUNT) begin
                reload_d[t] = (reload_q[t] & ~byte_mask_q) | (wdata_q & byte_mask_q);
              end else begin
                wmask   = byte_mask_q[CtlW-1:0] & CtlWritable;
                ctl_new = (ctl_q[t] & ~wmask) | (wdata_q[CtlW-1:0] & wmask);
                rise    = !ctl_q[t][CtlEnableBit] && wdata_q[CtlEnableBit]
                          && byte_mask_q[CtlEnableBit];
                if (rise) begin
                  cnt_d[t] = reload_q[t];
                end
                casc     = (t != 0) && ctl_q[t][CtlCascadeBit];
                casc_new = (t != 0) && ctl_new[CtlCascadeBit];
                // a shift change restarts the prescaler just like an enable edge
                restart  = rise || (last_phase(ctl_new[1:0], casc_new)
                                    != last_phase(ctl_q[t][1:0], casc));
                if (restart && ctl_new[CtlEnableBit] && !casc_new) begin
                  phase_d[t] = '0;
                end
                ctl_d[t] = ctl_new;
              end
            end
          end
        end
        default: begin
          // unused kind: no state change, zero result
        end
      endcase
    end
  end

  // only the first four timers have an irq line
  assign irq_wide = {{IrqW{1'b0}}, irq_hit};
  assign irq_d    = irq_wide[IrqW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        cnt_q[t]    <= '0;
        reload_q[t] <= '0;
        ctl_q[t]    <= '0;
        phase_q[t]  <= '0;
      end
    end else begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        cnt_q[t]    <= cnt_d[t];
        reload_q[t] <= reload_d[t];
        ctl_q[t]    <= ctl_d[t];
        phase_q[t]  <= phase_d[t];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      read_data_q <= read_data_d;
      irq_q       <= irq_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-DataW-IrqW){1'b0}}, irq_q, read_data_q};

  // reserved control bits never get set
  always_comb begin
    ctl_rsvd_any = 1'b0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      ctl_rsvd_any = ctl_rsvd_any || (ctl_q[t][5:3] != 3'b000);
    end
  end

  `CFTU_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q,
                    "processed item did not reach the result register")
  `CFTU_ASSERT_NEXT(a_stalled_item_kept, in_valid_q && !advance, in_valid_q,
                    "stalled input item was dropped")
  `CFTU_ASSERT_NEXT(a_irq_only_on_tick, advance && (kind_q != KIND_TICK), irq_q == '0,
                    "irq pulse on a non-tick item")
  `CFTU_ASSERT_NEXT(a_rdata_only_on_read, advance && (kind_q != KIND_READ),
                    read_data_q == '0, "read data on a non-read item")
  `CFTU_ASSERT_SAME(a_ctl_rsvd_zero, 1'b1, !ctl_rsvd_any,
                    "reserved control bits set")

endmodule
